@@ design/sfpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SENT frame pulse encoder package
// Shared types, codes and the CRC4 helper for the SENT frame pulse encoder.
// ----------------------------------------------------------------------------
package sfpe_pkg;

	localparam int unsigned NIB_W    = 4;
	localparam int unsigned LEN_W    = 10;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned TIME_W   = 17;
	localparam int unsigned TICK_W   = 10;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned SEL_MAXW = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 10;

	localparam logic [KIND_W-1:0] KIND_SYNC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STATUS = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DATA   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CRC    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PAUSE  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_VARIANT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_TENTHS  = 2'd3;

	localparam logic [LEN_W-1:0]  SYNC_TICKS  = 10'd56;
	localparam logic [LEN_W-1:0]  NIBBLE_BASE = 10'd12;
	localparam logic [LEN_W-1:0]  PAUSE_MIN   = 10'd12;
	localparam logic [LEN_W-1:0]  PAUSE_MAX   = 10'd768;
	localparam logic [TICK_W-1:0] TICK_MAX    = 10'd900;

	typedef struct packed {
		logic                load;
		logic                issue;
		logic [KIND_W-1:0]   kind;
		logic                bad;
		logic                last;
		logic [SEL_MAXW-1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic adv;
		logic pause_bad;
		logic pause_zero;
	} sts_t;

	// Multiplication by x^4 modulo x^4+x^3+x^2+1.
	function automatic logic [NIB_W-1:0] mul_x4(input logic [NIB_W-1:0] v);
		logic [NIB_W-1:0] r;
		unique case (v)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd13;
			4'd2:    r = 4'd7;
			4'd3:    r = 4'd10;
			4'd4:    r = 4'd14;
			4'd5:    r = 4'd3;
			4'd6:    r = 4'd9;
			4'd7:    r = 4'd4;
			4'd8:    r = 4'd1;
			4'd9:    r = 4'd12;
			4'd10:   r = 4'd6;
			4'd11:   r = 4'd11;
			4'd12:   r = 4'd15;
			4'd13:   r = 4'd2;
			4'd14:   r = 4'd8;
			default: r = 4'd5;
		endcase
		return r;
	endfunction

endpackage

@@ design/sent_frame_pulse_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SENT frame pulse encoder core
// Turns one SENT frame into its sync, status, data, CRC and pause intervals.
// ----------------------------------------------------------------------------
// A zero pause adds no pause interval; a pause out of range gives a single
// bad-frame interval. Throughput: one interval per cycle when the output is
// not stalled; a new frame is taken only once the previous frame has issued
// all its intervals. The interval sequencer in the controller sets this rate.
// Reset returns the registers to their defaults and empties the pipeline.
module sent_frame_pulse_encoder_core #(
	parameter int unsigned MAX_NIBBLES = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [sfpe_pkg::NIB_W-1:0]            status_nibble,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_0,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_1,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_2,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_3,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_4,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_5,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_6,
	input  logic [sfpe_pkg::NIB_W-1:0]            data_nibble_7,
	input  logic [sfpe_pkg::LEN_W-1:0]            pause_len,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [sfpe_pkg::LEN_W-1:0]            interval_len,
	output logic [sfpe_pkg::KIND_W-1:0]           pulse_kind,
	output logic [sfpe_pkg::TIME_W-1:0]           end_time_us,
	output logic                                  bad_frame,
	output logic                                  frame_end,
	input  logic                                  cfg_we,
	input  logic [sfpe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sfpe_pkg::CFG_DAT_W-1:0]        cfg_wdata
);
	import sfpe_pkg::*;

	logic [CNT_W-1:0]      nibble_count_q;
	logic                  crc_variant_q;
	logic [NIB_W-1:0]      crc_seed_q;
	logic [TICK_W-1:0]     tick_tenths_q;
	logic [7:0][NIB_W-1:0] nib_in;
	cmd_t                  cmd;
	sts_t                  sts;

	assign nib_in = {data_nibble_7, data_nibble_6, data_nibble_5, data_nibble_4,
		data_nibble_3, data_nibble_2, data_nibble_1, data_nibble_0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_count_q <= CNT_W'(6);
			crc_variant_q  <= 1'b1;
			crc_seed_q     <= NIB_W'(5);
			tick_tenths_q  <= TICK_W'(30);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NIBBLE_COUNT: nibble_count_q <= cfg_wdata[CNT_W-1:0];
				REG_CRC_VARIANT:  crc_variant_q  <= cfg_wdata[0];
				REG_CRC_SEED:     crc_seed_q     <= cfg_wdata[NIB_W-1:0];
				default:          tick_tenths_q  <= cfg_wdata[TICK_W-1:0];
			endcase
		end
	end

	sfpe_ctrl #(
		.MAX_NIBBLES(MAX_NIBBLES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.nibble_count (nibble_count_q),
		.sts          (sts),
		.cmd          (cmd)
	);

	sfpe_dp #(
		.MAX_NIBBLES(MAX_NIBBLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.nib_in         (nib_in),
		.status_in      (status_nibble),
		.pause_in       (pause_len),
		.crc_variant    (crc_variant_q),
		.crc_seed       (crc_seed_q),
		.tick_tenths_us (tick_tenths_q),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.interval_len   (interval_len),
		.pulse_kind     (pulse_kind),
		.end_time_us    (end_time_us),
		.bad_frame      (bad_frame),
		.frame_end      (frame_end)
	);

endmodule

@@ design/sfpe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SENT frame pulse encoder controller
// Sequences the intervals of one frame and issues one command per interval.
// ----------------------------------------------------------------------------
module sfpe_ctrl #(
	parameter int unsigned MAX_NIBBLES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [sfpe_pkg::CNT_W-1:0]  nibble_count,
	input  sfpe_pkg::sts_t              sts,
	output sfpe_pkg::cmd_t              cmd
);
	import sfpe_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NIBBLES);

	logic             state_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_eff;
	logic [CNT_W-1:0] pos_crc;
	logic [CNT_W-1:0] pos_sel;
	logic             done;

	always_comb begin
		if (nibble_count == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (nibble_count > MAX_CNT) begin
			cnt_eff = MAX_CNT;
		end else begin
			cnt_eff = nibble_count;
		end
	end

	assign pos_crc  = cnt_eff + CNT_W'(2);
	assign pos_sel  = pos_q - CNT_W'(2);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		done      = 1'b0;
		cmd.load  = in_valid && (state_q == ST_IDLE);
		cmd.sel   = pos_sel[SEL_MAXW-1:0];
		if (state_q == ST_EMIT && sts.adv) begin
			cmd.issue = 1'b1;
			if (pos_q == '0) begin
				if (sts.pause_bad) begin
					cmd.bad  = 1'b1;
					cmd.last = 1'b1;
					done     = 1'b1;
				end else begin
					cmd.kind = KIND_SYNC;
				end
			end else if (pos_q == CNT_W'(1)) begin
				cmd.kind = KIND_STATUS;
			end else if (pos_q < pos_crc) begin
				cmd.kind = KIND_DATA;
			end else if (pos_q == pos_crc) begin
				cmd.kind = KIND_CRC;
				cmd.last = sts.pause_zero;
				done     = sts.pause_zero;
			end else begin
				cmd.kind = KIND_PAUSE;
				cmd.last = 1'b1;
				done     = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EMIT;
						pos_q   <= '0;
					end
				end
				default: begin
					if (cmd.issue) begin
						if (done) begin
							state_q <= ST_IDLE;
						end
						pos_q <= pos_q + CNT_W'(1);
					end
				end
			endcase
		end
	end

endmodule

@@ design/sfpe_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SENT frame pulse encoder datapath
// Holds the frame, runs the CRC4 and computes interval lengths and end times.
// ----------------------------------------------------------------------------
module sfpe_dp #(
	parameter int unsigned MAX_NIBBLES = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sfpe_pkg::cmd_t                        cmd,
	output sfpe_pkg::sts_t                        sts,
	input  logic [7:0][sfpe_pkg::NIB_W-1:0]       nib_in,
	input  logic [sfpe_pkg::NIB_W-1:0]            status_in,
	input  logic [sfpe_pkg::LEN_W-1:0]            pause_in,
	input  logic                                  crc_variant,
	input  logic [sfpe_pkg::NIB_W-1:0]            crc_seed,
	input  logic [sfpe_pkg::TICK_W-1:0]           tick_tenths_us,
	input  logic                                  out_stall,
	output logic                                  out_valid,
	output logic [sfpe_pkg::LEN_W-1:0]            interval_len,
	output logic [sfpe_pkg::KIND_W-1:0]           pulse_kind,
	output logic [sfpe_pkg::TIME_W-1:0]           end_time_us,
	output logic                                  bad_frame,
	output logic                                  frame_end
);
	import sfpe_pkg::*;

	localparam int unsigned SEL_W   = (MAX_NIBBLES > 1) ? $clog2(MAX_NIBBLES) : 1;
	localparam int unsigned CUM_W   = 11;
	localparam int unsigned ACC_W   = 20;
	localparam int unsigned SUM_W   = 21;
	localparam int unsigned RCP_W   = 20;
	localparam int unsigned RCP_SH  = 23;
	localparam logic [RCP_W-1:0] RECIP_TEN = 20'd838861;
	localparam logic [SUM_W-1:0] ROUND_HALF = 21'd5;

	logic [NIB_W-1:0]  held_nib_q [MAX_NIBBLES];
	logic [NIB_W-1:0]  held_status_q;
	logic [LEN_W-1:0]  held_pause_q;
	logic [NIB_W-1:0]  crc_q;
	logic [CUM_W-1:0]  cum_q;

	logic [NIB_W-1:0]  sel_nib;
	logic [NIB_W-1:0]  crc_final;
	logic [LEN_W-1:0]  len;
	logic [CUM_W-1:0]  cum_next;
	logic [TICK_W-1:0] tick_eff;
	logic              adv;

	logic              v1_s1, v2_s2, v3_s3;
	logic [LEN_W-1:0]  len_s1, len_s2;
	logic [KIND_W-1:0] kind_s1, kind_s2;
	logic              bad_s1, bad_s2, last_s1, last_s2;
	logic [CUM_W-1:0]  cum_s1;
	logic [ACC_W-1:0]  acc_s2;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W+RCP_W-1:0] quot_full;

	assign adv     = !v3_s3 || !out_stall;
	assign sts.adv = adv;
	assign sts.pause_zero = (held_pause_q == '0);
	assign sts.pause_bad  = (held_pause_q != '0) &&
		((held_pause_q < PAUSE_MIN) || (held_pause_q > PAUSE_MAX));

	assign sel_nib   = held_nib_q[cmd.sel[SEL_W-1:0]];
	assign crc_final = crc_variant ? mul_x4(crc_q) : crc_q;

	always_comb begin
		if (tick_tenths_us == '0) begin
			tick_eff = TICK_W'(1);
		end else if (tick_tenths_us > TICK_MAX) begin
			tick_eff = TICK_MAX;
		end else begin
			tick_eff = tick_tenths_us;
		end
	end

	always_comb begin
		if (cmd.bad) begin
			len = '0;
		end else begin
			case (cmd.kind)
				KIND_SYNC:   len = SYNC_TICKS;
				KIND_STATUS: len = NIBBLE_BASE + LEN_W'(held_status_q);
				KIND_DATA:   len = NIBBLE_BASE + LEN_W'(sel_nib);
				KIND_CRC:    len = NIBBLE_BASE + LEN_W'(crc_final);
				default:     len = held_pause_q;
			endcase
		end
	end

	assign cum_next = cum_q + CUM_W'(len);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < MAX_NIBBLES; i++) begin
				held_nib_q[i] <= nib_in[i];
			end
			held_status_q <= status_in;
			held_pause_q  <= pause_in;
			crc_q         <= crc_seed;
			cum_q         <= '0;
		end else if (cmd.issue) begin
			cum_q <= cum_next;
			if (cmd.kind == KIND_DATA && !cmd.bad) begin
				crc_q <= mul_x4(crc_q) ^ sel_nib;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else if (adv) begin
			v1_s1 <= cmd.issue;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
		end
	end

	assign sum       = SUM_W'(acc_s2) + ROUND_HALF;
	assign quot_full = sum * RECIP_TEN;

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s1       <= len;
			kind_s1      <= cmd.kind;
			bad_s1       <= cmd.bad;
			last_s1      <= cmd.last;
			cum_s1       <= cmd.bad ? '0 : cum_next;
			len_s2       <= len_s1;
			kind_s2      <= kind_s1;
			bad_s2       <= bad_s1;
			last_s2      <= last_s1;
			acc_s2       <= ACC_W'(cum_s1) * ACC_W'(tick_eff);
			interval_len <= len_s2;
			pulse_kind   <= kind_s2;
			bad_frame    <= bad_s2;
			frame_end    <= last_s2;
			end_time_us  <= quot_full[RCP_SH +: TIME_W];
		end
	end

	assign out_valid = v3_s3;

endmodule

@@ tb/sv/sent_frame_pulse_encoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SENT frame pulse encoder core testbench
// Sends SENT frames through the encoder under several register settings and
// random idling on both sides. A scoreboard predicts every interval of each
// frame and checks each output transfer in order, field by field.
// ----------------------------------------------------------------------------
module sent_frame_pulse_encoder_core_tb;

	import sfpe_pkg::*;

	localparam int unsigned MAX_NIBBLES = 8;
	localparam int unsigned ROUND_HALF  = 5;
	localparam int unsigned TENTHS      = 10;
	localparam int unsigned HOLD_CYCLES = 160;

	typedef struct packed {
		logic [NIB_W-1:0]        status;
		logic [7:0][NIB_W-1:0]   data;
		logic [LEN_W-1:0]        pause;
	} frame_t;

	typedef struct packed {
		logic [LEN_W-1:0]  interval_len;
		logic [KIND_W-1:0] pulse_kind;
		logic [TIME_W-1:0] end_time_us;
		logic              bad_frame;
		logic              frame_end;
	} interval_t;

	class frame_scoreboard;
		int unsigned nibble_count = 6;
		int unsigned crc_variant  = 1;
		int unsigned crc_seed     = 5;
		int unsigned tick_tenths  = 30;
		int unsigned time_tenths;
		int unsigned errors;
		interval_t   interval_q[$];

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_NIBBLE_COUNT: nibble_count = val[3:0];
				REG_CRC_VARIANT:  crc_variant  = val[0];
				REG_CRC_SEED:     crc_seed     = val[3:0];
				REG_TICK_TENTHS:  tick_tenths  = val;
				default: ;
			endcase
		endfunction

		// Four shifts by x, each reduced by x^4+x^3+x^2+1.
		function logic [NIB_W-1:0] times_x4(logic [NIB_W-1:0] v);
			logic [NIB_W:0] acc;
			acc = {1'b0, v};
			repeat (4) begin
				acc = acc << 1;
				if (acc[NIB_W])
					acc = acc ^ 5'h1D;
			end
			return acc[NIB_W-1:0];
		endfunction

		function void add_interval(int unsigned len, logic [KIND_W-1:0] kind, bit last,
				int unsigned tick);
			interval_t r;
			time_tenths = (time_tenths + len * tick) & 32'hFFFFF;
			r.interval_len = LEN_W'(len);
			r.pulse_kind   = kind;
			r.end_time_us  = TIME_W'((time_tenths + ROUND_HALF) / TENTHS);
			r.bad_frame    = 1'b0;
			r.frame_end    = last;
			interval_q.push_back(r);
		endfunction

		function void note_frame(frame_t f);
			int unsigned count;
			int unsigned tick;
			logic [NIB_W-1:0] crc;
			interval_t r;
			count = nibble_count;
			if (count < 1)
				count = 1;
			if (count > MAX_NIBBLES)
				count = MAX_NIBBLES;
			tick = tick_tenths;
			if (tick < 1)
				tick = 1;
			if (tick > TICK_MAX)
				tick = TICK_MAX;
			time_tenths = 0;
			if (f.pause != 0 && (f.pause < PAUSE_MIN || f.pause > PAUSE_MAX)) begin
				r = '0;
				r.bad_frame = 1'b1;
				r.frame_end = 1'b1;
				interval_q.push_back(r);
				return;
			end
			crc = NIB_W'(crc_seed);
			for (int i = 0; i < count; i++)
				crc = times_x4(crc) ^ f.data[i];
			if (crc_variant != 0)
				crc = times_x4(crc);
			add_interval(SYNC_TICKS, KIND_SYNC, 1'b0, tick);
			add_interval(NIBBLE_BASE + f.status, KIND_STATUS, 1'b0, tick);
			for (int i = 0; i < count; i++)
				add_interval(NIBBLE_BASE + f.data[i], KIND_DATA, 1'b0, tick);
			add_interval(NIBBLE_BASE + crc, KIND_CRC, f.pause == 0, tick);
			if (f.pause != 0)
				add_interval(f.pause, KIND_PAUSE, 1'b1, tick);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_interval(interval_t got);
			interval_t want;
			if (interval_q.size() == 0) begin
				$error("Unexpected interval transfer: kind %0d, length %0d",
					got.pulse_kind, got.interval_len);
				errors++;
				return;
			end
			want = interval_q.pop_front();
			compare_field("interval_len", want.interval_len, got.interval_len);
			compare_field("pulse_kind", want.pulse_kind, got.pulse_kind);
			compare_field("end_time_us", want.end_time_us, got.end_time_us);
			compare_field("bad_frame", want.bad_frame, got.bad_frame);
			compare_field("frame_end", want.frame_end, got.frame_end);
		endfunction

		function int unsigned pending();
			return interval_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [NIB_W-1:0]      status_nibble;
	logic [NIB_W-1:0]      data_nibble_0;
	logic [NIB_W-1:0]      data_nibble_1;
	logic [NIB_W-1:0]      data_nibble_2;
	logic [NIB_W-1:0]      data_nibble_3;
	logic [NIB_W-1:0]      data_nibble_4;
	logic [NIB_W-1:0]      data_nibble_5;
	logic [NIB_W-1:0]      data_nibble_6;
	logic [NIB_W-1:0]      data_nibble_7;
	logic [LEN_W-1:0]      pause_len;
	logic                  out_valid;
	logic                  out_stall;
	logic [LEN_W-1:0]      interval_len;
	logic [KIND_W-1:0]     pulse_kind;
	logic [TIME_W-1:0]     end_time_us;
	logic                  bad_frame;
	logic                  frame_end;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_wdata;

	frame_scoreboard sb;
	int unsigned     sender_idle_pct;
	int unsigned     recv_stall_pct;
	bit              hold_req;

	sent_frame_pulse_encoder_core #(
		.MAX_NIBBLES(MAX_NIBBLES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status_nibble(status_nibble),
		.data_nibble_0(data_nibble_0),
		.data_nibble_1(data_nibble_1),
		.data_nibble_2(data_nibble_2),
		.data_nibble_3(data_nibble_3),
		.data_nibble_4(data_nibble_4),
		.data_nibble_5(data_nibble_5),
		.data_nibble_6(data_nibble_6),
		.data_nibble_7(data_nibble_7),
		.pause_len(pause_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.interval_len(interval_len),
		.pulse_kind(pulse_kind),
		.end_time_us(end_time_us),
		.bad_frame(bad_frame),
		.frame_end(frame_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin : monitor
		interval_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.interval_len = interval_len;
			seen.pulse_kind   = pulse_kind;
			seen.end_time_us  = end_time_us;
			seen.bad_frame    = bad_frame;
			seen.frame_end    = frame_end;
			sb.check_interval(seen);
		end
	end

	// The receiver holds off for a long stretch when asked, so that the
	// encoder fills up and stalls its input.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic frame_t make_frame(logic [NIB_W-1:0] status, logic [NIB_W-1:0] fill,
			logic [LEN_W-1:0] pause);
		frame_t f;
		f.status = status;
		for (int i = 0; i < 8; i++)
			f.data[i] = fill;
		f.pause = pause;
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int unsigned pick;
		f.status = NIB_W'($urandom_range(15));
		for (int i = 0; i < 8; i++)
			f.data[i] = NIB_W'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 15)
			f.pause = '0;
		else if (pick < 85)
			f.pause = LEN_W'($urandom_range(PAUSE_MAX, PAUSE_MIN));
		else if (pick < 92)
			f.pause = LEN_W'($urandom_range(PAUSE_MIN - 1, 1));
		else
			f.pause = LEN_W'($urandom_range(1023, PAUSE_MAX + 1));
		return f;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_frame(frame_t f);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		status_nibble <= f.status;
		data_nibble_0 <= f.data[0];
		data_nibble_1 <= f.data[1];
		data_nibble_2 <= f.data[2];
		data_nibble_3 <= f.data[3];
		data_nibble_4 <= f.data[4];
		data_nibble_5 <= f.data[5];
		data_nibble_6 <= f.data[6];
		data_nibble_7 <= f.data[7];
		pause_len     <= f.pause;
		in_valid      <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_frame(f);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(int k);
		logic [CFG_DAT_W-1:0] count, variant, seed, tick;
		case (k)
			0: begin count = 1;  variant = 0; seed = 0;  tick = 1;    end
			1: begin count = 8;  variant = 1; seed = 15; tick = 900;  end
			2: begin count = 0;  variant = 0; seed = 9;  tick = 0;    end
			3: begin count = 15; variant = 1; seed = 3;  tick = 1023; end
			4: begin count = 4;  variant = 1; seed = 15; tick = 899;  end
			5: begin count = 9;  variant = 0; seed = 12; tick = 450;  end
			default: begin
				count   = CFG_DAT_W'($urandom_range(8, 1));
				variant = CFG_DAT_W'($urandom_range(1));
				seed    = CFG_DAT_W'($urandom_range(15));
				tick    = CFG_DAT_W'($urandom_range(900, 1));
			end
		endcase
		write_reg(REG_NIBBLE_COUNT, count);
		write_reg(REG_CRC_VARIANT, variant);
		write_reg(REG_CRC_SEED, seed);
		write_reg(REG_TICK_TENTHS, tick);
	endtask

	initial begin
		sb = new();
		hold_req        = 1'b0;
		sender_idle_pct = 11;
		recv_stall_pct  = 56;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		status_nibble   = '0;
		data_nibble_0   = '0;
		data_nibble_1   = '0;
		data_nibble_2   = '0;
		data_nibble_3   = '0;
		data_nibble_4   = '0;
		data_nibble_5   = '0;
		data_nibble_6   = '0;
		data_nibble_7   = '0;
		pause_len       = '0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Field extremes and every kind of invalid pause, at the reset settings.
		send_frame(make_frame(0, 0, 0));
		send_frame(make_frame(15, 15, 0));
		send_frame(make_frame(15, 15, PAUSE_MAX));
		send_frame(make_frame(0, 0, PAUSE_MIN));
		send_frame(make_frame(15, 0, 100));
		send_frame(make_frame(0, 15, 513));
		send_frame(make_frame(5, 10, 256));
		send_frame(make_frame(10, 5, 0));
		send_frame(make_frame(3, 7, PAUSE_MIN - 1));
		send_frame(make_frame(3, 7, PAUSE_MAX + 1));
		send_frame(make_frame(3, 7, 1));
		send_frame(make_frame(3, 7, 1023));
		send_frame(make_frame(8, 1, 767));
		send_frame(make_frame(1, 8, 13));

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 11; recv_stall_pct = 56; end
				1: begin sender_idle_pct = 56; recv_stall_pct = 11; end
				default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int s = 0; s < 3; s++) begin
				drain();
				apply_setting(phase * 3 + s);
				if (phase == 2 && s == 0)
					hold_req = 1'b1;
				send_frame(make_frame(15, 15, PAUSE_MAX));
				repeat (36) send_frame(random_frame());
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
